>>> hw/rtl/pch_pkg.sv
// Shared types and constants for the programmable CRC name hash match block.
// No dependencies; imported by every module of the block.
package pch_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StepsPerByte = 8;

  localparam logic [HashW-1:0] HashInit = 32'hFFFF_FFFF;

  localparam logic [PosW-1:0] PosFirst = 2'd0;
  localparam logic [PosW-1:0] PosSecond = 2'd1;
  localparam logic [PosW-1:0] PosThird = 2'd2;
  localparam logic [PosW-1:0] PosBeyond = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgPolynomial = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetHash = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgExpectSecond = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgExpectThird = 2'd3;

  typedef struct packed {
    logic [HashW-1:0] hash_value;
    logic is_match;
  } result_t;

endpackage

>>> hw/rtl/pch_absorb.sv
// Byte absorb unit: signed-char fold plus eight reflected shift-and-XOR steps.
// Depends on pch_pkg.
module pch_absorb (
  input  logic [pch_pkg::HashW-1:0] hash_i,
  input  logic [pch_pkg::ByteW-1:0] byte_i,
  input  logic [pch_pkg::HashW-1:0] poly_i,
  output logic [pch_pkg::HashW-1:0] hash_o
);
  import pch_pkg::*;

  logic [HashW-ByteW-1:0] upper;
  logic [HashW-1:0] mixed;

  // a byte with its top bit set takes one from the upper bits
  assign upper = hash_i[HashW-1:ByteW] - {{(HashW-ByteW-1){1'b0}}, byte_i[ByteW-1]};

  always_comb begin
    mixed = {upper, hash_i[ByteW-1:0] ^ byte_i};
    for (int unsigned k = 0; k < StepsPerByte; k++) begin
      if (mixed[0]) begin
        mixed = (mixed >> 1) ^ poly_i;
      end else begin
        mixed = mixed >> 1;
      end
    end
  end

  assign hash_o = mixed;

endmodule

>>> hw/rtl/pch_out_reg.sv
// Result register with valid/ready towards the consumer.
// Depends on pch_pkg.
module pch_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  pch_pkg::result_t           res_i,
  output logic                       can_load_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pch_pkg::HashW-1:0]  hash_value_o,
  output logic                       is_match_o
);
  import pch_pkg::*;

  logic valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign hash_value_o = res_q.hash_value;
  assign is_match_o = res_q.is_match;

endmodule

>>> hw/rtl/programmable_crc_name_hash_match_core.sv
// The last word passes the input register, then the result register, before its result is valid.
// Throughput: one name byte per cycle unless a last word stalls (below); set by the eight-step absorb path.
// A result register decouples the output: other words flow while a result waits; a last word
// stalls only while the result register is full and out_ready_i is low.
// Reset: configuration registers clear to zero, running hash to all ones, prefix state to zero.
// Depends on pch_pkg, pch_absorb and pch_out_reg.
module programmable_crc_name_hash_match_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pch_pkg::HashW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pch_pkg::ByteW-1:0]    name_byte_i,
  input  logic                         is_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pch_pkg::HashW-1:0]    hash_value_o,
  output logic                         is_match_o
);
  import pch_pkg::*;

  logic [HashW-1:0] poly_q, target_q;
  logic [ByteW-1:0] exp_second_q, exp_third_q;

  logic in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic in_last_q;

  logic [HashW-1:0] hash_q, hash_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic second_ok_q, second_ok_d;
  logic third_ok_q, third_ok_d;

  logic [HashW-1:0] hash_next;
  logic [PosW-1:0] pos_next;
  logic second_next, third_next, second_fin, third_fin;
  logic advance, can_load, load;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= '0;
      target_q <= '0;
      exp_second_q <= '0;
      exp_third_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPolynomial:   poly_q <= cfg_wdata_i;
        CfgTargetHash:   target_q <= cfg_wdata_i;
        CfgExpectSecond: exp_second_q <= cfg_wdata_i[ByteW-1:0];
        CfgExpectThird:  exp_third_q <= cfg_wdata_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign advance = in_vld_q && (!in_last_q || can_load);
  assign in_ready_o = !in_vld_q || advance;
  assign load = advance && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= name_byte_i;
      in_last_q <= is_last_i;
    end
  end

  pch_absorb u_absorb (
    .hash_i (hash_q),
    .byte_i (in_byte_q),
    .poly_i (poly_q),
    .hash_o (hash_next)
  );

  always_comb begin
    pos_next = (pos_q == PosBeyond) ? pos_q : pos_q + PosW'(1);
    second_next = (pos_q == PosSecond) ? (in_byte_q == exp_second_q) : second_ok_q;
    third_next = (pos_q == PosThird) ? (in_byte_q == exp_third_q) : third_ok_q;
    // positions never reached read as zero
    second_fin = (pos_next == PosFirst || pos_next == PosSecond) ?
                 (exp_second_q == '0) : second_next;
    third_fin = (pos_next != PosBeyond) ? (exp_third_q == '0) : third_next;
    res.hash_value = hash_next;
    res.is_match = second_fin && third_fin && (hash_next == target_q);
  end

  always_comb begin
    hash_d = hash_q;
    pos_d = pos_q;
    second_ok_d = second_ok_q;
    third_ok_d = third_ok_q;
    if (advance) begin
      if (in_last_q) begin
        hash_d = HashInit;
        pos_d = PosFirst;
        second_ok_d = 1'b0;
        third_ok_d = 1'b0;
      end else begin
        hash_d = hash_next;
        pos_d = pos_next;
        second_ok_d = second_next;
        third_ok_d = third_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashInit;
      pos_q <= PosFirst;
      second_ok_q <= 1'b0;
      third_ok_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      pos_q <= pos_d;
      second_ok_q <= second_ok_d;
      third_ok_q <= third_ok_d;
    end
  end

  pch_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .res_i        (res),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o),
    .is_match_o   (is_match_o)
  );

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (hash_q == HashInit) && (pos_q == PosFirst))
    else $error("name state not restarted after last word");

  a_no_result_mid_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_last_q && !out_valid_o) |=> !out_valid_o)
    else $error("result raised by a word without the last mark");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_last_q && pos_q == PosBeyond) |=> (pos_q == PosBeyond))
    else $error("character position wrapped");

  a_stall_holds_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && in_last_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a waiting result");

endmodule
